// File: src/spm_pkg.sv
// Shared constants, codes and types of the string pattern matcher.
package spm_pkg;

    // Window depth default and fixed pattern storage
    localparam int PATTERN_MAX_DEF = 32;
    localparam int PAT_BYTES       = 32;
    localparam int PB_IDX_W        = $clog2(PAT_BYTES);
    localparam int LEN_W           = 6;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] REG_MODE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LENGTH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MISSING = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PAT0    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PAT1    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PAT2    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_PAT3    = 3'd6;

    // Match modes
    localparam logic [1:0] MODE_EXACT    = 2'd0;
    localparam logic [1:0] MODE_PREFIX   = 2'd1;
    localparam logic [1:0] MODE_SUFFIX   = 2'd2;
    localparam logic [1:0] MODE_CONTAINS = 2'd3;

    // Verdict codes
    localparam logic [1:0] VERDICT_FALSE   = 2'd0;
    localparam logic [1:0] VERDICT_TRUE    = 2'd1;
    localparam logic [1:0] VERDICT_ABSTAIN = 2'd2;

    localparam int OUT_DATA_W = 8;

    // Per-cycle control shared by every window cell
    typedef struct packed {
        logic shift;
        logic clear;
    } cell_ctrl_t;

endpackage

// File: src/string_pattern_matcher_unit.sv
// Top level of the string pattern matcher: configuration, stream state and window cell row.
//
// Usage
//   Configure through cfg_we / cfg_index / cfg_data while the block is idle:
//   index 0 match mode, 1 pattern length, 2 pattern missing, 3..6 pattern bytes
//   (eight bytes each, lowest byte first). Other indexes are ignored.
//   Stream the context on the s_ channel, one byte per request: s_tdata holds the
//   byte, s_tlast marks the final request of a string, s_tuser[0] flags an empty
//   context and s_tuser[1] a missing one. Each string ends in one verdict request
//   on the m_ channel: m_tdata[1:0] is 0 false, 1 true, 2 abstain.
// Timing
//   One request per cycle sustained while s_tready is high. The verdict is
//   registered. The window is a row of PATTERN_MAX cells that shift one
//   place per byte, so the per-byte work is one compare in each cell and an AND.
// Stall and reset
//   A stalled verdict waits in the output register; a second verdict goes to a
//   skid stage and only then is s_tready dropped, until the m_ side drains.
//   Reset clears the configuration, the stream state and both output stages;
//   no clearing pass is needed; s_tready is high with the skid stage empty.
module string_pattern_matcher_unit #(
    parameter int PATTERN_MAX = spm_pkg::PATTERN_MAX_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Configuration write port
    input  logic                           cfg_we,
    input  logic [spm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [spm_pkg::CFG_DATA_W-1:0] cfg_data,
    // Context stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,   // [7:0] ctx_byte
    input  logic                           s_tlast,   // is_last
    input  logic [1:0]                     s_tuser,   // [0] is_empty, [1] ctx_missing
    // Verdict stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [7:0]                     m_tdata    // [1:0] verdict, [7:2] zero
);

    localparam int LEN_W    = spm_pkg::LEN_W;
    localparam int SEEN_W   = $clog2(PATTERN_MAX + 2);
    localparam int CMP_W    = (SEEN_W > LEN_W) ? SEEN_W : LEN_W;
    localparam int PB       = spm_pkg::PAT_BYTES;
    localparam int PB_IDX_W = spm_pkg::PB_IDX_W;
    // Longest usable pattern: bytes past the stored ones read as zero
    localparam int LIM_MAX  = (PATTERN_MAX < PB) ? PATTERN_MAX : PB;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [1:0]               mode_reg,  mode_next;
    logic [LEN_W-1:0]         plen_reg,  plen_next;
    logic                     pmiss_reg, pmiss_next;
    logic [PB-1:0][7:0]       pat_reg,   pat_next;

    always_comb begin
        mode_next  = mode_reg;
        plen_next  = plen_reg;
        pmiss_next = pmiss_reg;
        pat_next   = pat_reg;
        if (cfg_we) begin
            case (cfg_index)
                spm_pkg::REG_MODE:    mode_next  = cfg_data[1:0];
                spm_pkg::REG_LENGTH:  plen_next  = cfg_data[LEN_W-1:0];
                spm_pkg::REG_MISSING: pmiss_next = cfg_data[0];
                spm_pkg::REG_PAT0:    pat_next[7:0]   = cfg_data;
                spm_pkg::REG_PAT1:    pat_next[15:8]  = cfg_data;
                spm_pkg::REG_PAT2:    pat_next[23:16] = cfg_data;
                spm_pkg::REG_PAT3:    pat_next[31:24] = cfg_data;
                default: ;
            endcase
        end
    end

    // Effective length: clip to the window depth and the stored bytes, then cut
    // at the first zero byte.
    // Worked out from the incoming configuration so the derived values land with it.
    logic [LEN_W-1:0] lim_next;
    logic [LEN_W-1:0] len_reg, len_next;

    always_comb begin
        lim_next = plen_next;
        if (int'(plen_next) > LIM_MAX) begin
            lim_next = LEN_W'(LIM_MAX);
        end
        len_next = lim_next;
        for (int k = PB - 1; k >= 0; k--) begin
            if (LEN_W'(k) < lim_next && pat_next[k] == 8'h00) begin
                len_next = LEN_W'(k);
            end
        end
    end

    // Per-cell expected byte: cell i (i-th newest byte) checks pattern[len-1-i]
    logic [PATTERN_MAX-1:0]      act_reg, act_next;
    logic [PATTERN_MAX-1:0][7:0] exp_reg, exp_next;

    always_comb begin
        logic [LEN_W-1:0] pos;
        for (int i = 0; i < PATTERN_MAX; i++) begin
            act_next[i] = (i < int'(len_next));
            exp_next[i] = 8'h00;
            pos         = '0;
            if (i < int'(len_next)) begin
                pos         = len_next - LEN_W'(1) - LEN_W'(i);
                exp_next[i] = pat_next[pos[PB_IDX_W-1:0]];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= spm_pkg::MODE_EXACT;
            plen_reg  <= '0;
            pmiss_reg <= 1'b0;
            pat_reg   <= '0;
            len_reg   <= '0;
            act_reg   <= '0;
            exp_reg   <= '0;
        end else begin
            mode_reg  <= mode_next;
            plen_reg  <= plen_next;
            pmiss_reg <= pmiss_next;
            pat_reg   <= pat_next;
            len_reg   <= len_next;
            act_reg   <= act_next;
            exp_reg   <= exp_next;
        end
    end

    // ------------------------------------------------------------------
    // Input request decode
    // ------------------------------------------------------------------
    logic       acc, take, last;
    logic       out_space;
    logic [7:0] ctx_b;

    assign s_tready = out_space;
    assign acc      = s_tvalid && s_tready;
    // Drop the byte of an empty or missing request
    assign take     = acc && !s_tuser[0] && !s_tuser[1];
    assign last     = acc && s_tlast;
    assign ctx_b    = s_tdata;

    // ------------------------------------------------------------------
    // Window cell row: newest byte in cell 0, advance one place per byte
    // ------------------------------------------------------------------
    spm_pkg::cell_ctrl_t     cell_ctrl;
    logic [PATTERN_MAX:0][7:0] chain;
    logic [PATTERN_MAX-1:0]  hits;

    assign cell_ctrl.shift = take;
    assign cell_ctrl.clear = last;
    assign chain[0]        = ctx_b;

    for (genvar g = 0; g < PATTERN_MAX; g++) begin : g_cell
        spm_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctrl     (cell_ctrl),
            .byte_in  (chain[g]),
            .exp_byte (exp_reg[g]),
            .active   (act_reg[g]),
            .byte_out (chain[g+1]),
            .hit      (hits[g])
        );
    end

    // ------------------------------------------------------------------
    // Stream state
    // ------------------------------------------------------------------
    logic [SEEN_W-1:0] seen_reg, seen_step;
    logic              prefix_reg, prefix_step;
    logic              substr_reg, substr_step;
    logic              below_len;
    logic              tail_now;
    logic [7:0]        head_byte;

    assign below_len = CMP_W'(seen_reg) < CMP_W'(len_reg);
    assign head_byte = pat_reg[PB_IDX_W'(seen_reg)];

    always_comb begin
        seen_step   = seen_reg;
        prefix_step = prefix_reg;
        if (take) begin
            if (below_len && ctx_b != head_byte) begin
                prefix_step = 1'b0;
            end
            // Saturate one past the window depth
            if (seen_reg < SEEN_W'(PATTERN_MAX + 1)) begin
                seen_step = seen_reg + SEEN_W'(1);
            end
        end
    end

    // Tail of the window, after this request, against the whole pattern
    assign tail_now    = (CMP_W'(seen_step) >= CMP_W'(len_reg)) && (&hits);
    assign substr_step = substr_reg || (take && tail_now);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg   <= '0;
            prefix_reg <= 1'b1;
            substr_reg <= 1'b0;
        end else if (last) begin
            // Clear the stream state for the next string
            seen_reg   <= '0;
            prefix_reg <= 1'b1;
            substr_reg <= 1'b0;
        end else begin
            seen_reg   <= seen_step;
            prefix_reg <= prefix_step;
            substr_reg <= substr_step;
        end
    end

    // ------------------------------------------------------------------
    // Verdict
    // ------------------------------------------------------------------
    logic       ok;
    logic [1:0] verdict;

    always_comb begin
        case (mode_reg)
            spm_pkg::MODE_EXACT:
                ok = prefix_step && (CMP_W'(seen_step) == CMP_W'(len_reg));
            spm_pkg::MODE_PREFIX:
                ok = prefix_step && (CMP_W'(seen_step) >= CMP_W'(len_reg));
            spm_pkg::MODE_SUFFIX:
                ok = tail_now;
            default:
                ok = (len_reg == '0) || substr_step;
        endcase
        if (pmiss_reg || s_tuser[1]) begin
            verdict = spm_pkg::VERDICT_ABSTAIN;
        end else if (ok) begin
            verdict = spm_pkg::VERDICT_TRUE;
        end else begin
            verdict = spm_pkg::VERDICT_FALSE;
        end
    end

    spm_out_buf #(
        .DATA_W (spm_pkg::OUT_DATA_W)
    ) u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (last),
        .in_data  ({6'b000000, verdict}),
        .space    (out_space),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// File: src/spm_cell.sv
// One window cell: holds one context byte and compares it with its pattern byte.
module spm_cell (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  spm_pkg::cell_ctrl_t  ctrl,
    input  logic [7:0]           byte_in,
    input  logic [7:0]           exp_byte,
    input  logic                 active,
    output logic [7:0]           byte_out,
    output logic                 hit
);

    logic [7:0] byte_reg;
    logic [7:0] byte_next;
    logic [7:0] cmp_byte;

    // Compare the byte this cell holds once the current request has moved the window
    assign cmp_byte = ctrl.shift ? byte_in : byte_reg;
    assign hit      = !active || (cmp_byte == exp_byte);

    always_comb begin
        byte_next = byte_reg;
        if (ctrl.clear) begin
            byte_next = 8'h00;
        end else if (ctrl.shift) begin
            byte_next = byte_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_reg <= 8'h00;
        end else begin
            byte_reg <= byte_next;
        end
    end

    assign byte_out = byte_reg;

endmodule

// File: src/spm_out_buf.sv
// Output register with a skid stage for verdict requests.
module spm_out_buf #(
    parameter int DATA_W = spm_pkg::OUT_DATA_W
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    input  logic [DATA_W-1:0] in_data,
    output logic              space,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [DATA_W-1:0] m_tdata
);

    logic              main_valid_reg;
    logic [DATA_W-1:0] main_data_reg;
    logic              skid_valid_reg;
    logic [DATA_W-1:0] skid_data_reg;
    logic              drain;

    assign drain = main_valid_reg && m_tready;
    assign space = !skid_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            // Upstream is held while the skid stage is full
            if (drain) begin
                main_data_reg  <= skid_data_reg;
                skid_valid_reg <= 1'b0;
            end
        end else if (in_valid) begin
            if (!main_valid_reg || drain) begin
                main_valid_reg <= 1'b1;
                main_data_reg  <= in_data;
            end else begin
                skid_valid_reg <= 1'b1;
                skid_data_reg  <= in_data;
            end
        end else if (drain) begin
            main_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid = main_valid_reg;
    assign m_tdata  = main_data_reg;

endmodule

// File: src/spm_checker.sv
// Port-level checks of the string pattern matcher, bound to the top level.
module spm_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       s_tlast,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata
);

    // Hold a stalled verdict
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled verdict changed or dropped");

    // Only defined verdict codes, upper bits zero
    a_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[7:2] == 6'd0) && (m_tdata[1:0] <= spm_pkg::VERDICT_ABSTAIN))
        else $error("bad verdict code");

    // A new verdict follows a last byte taken in the previous cycle
    a_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready && s_tlast))
        else $error("verdict without a last request");

    // Input back-pressure only after an output stall
    a_bp: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(s_tready) |-> $past(m_tvalid && !m_tready))
        else $error("input held without an output stall");

    // Output empty after reset
    a_rst: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("verdict valid after reset");

endmodule

bind string_pattern_matcher_unit spm_checker u_spm_checker (.*);

// File: sim/tb_top.sv
// Self-checking testbench for the string pattern matcher unit.
module tb_top;

    localparam int WIN         = spm_pkg::PATTERN_MAX_DEF;
    localparam int STALL_LIMIT = 2000;
    localparam int PHASES      = 12;
    localparam int PHASE_REQS  = 68;
    localparam int IDX_W       = spm_pkg::CFG_IDX_W;
    localparam int DATA_W      = spm_pkg::CFG_DATA_W;

    typedef struct packed {
        logic [7:0] ctx_byte;
        logic       is_last;
        logic       is_empty;
        logic       ctx_missing;
    } ctx_req_t;

    typedef enum logic {ROW_REG, ROW_REQ} row_kind_t;

    typedef struct {
        row_kind_t              kind;
        logic [IDX_W-1:0]       idx;
        logic [DATA_W-1:0]      val;
        ctx_req_t               req;
        bit                     typed;
        logic [1:0]             want;
    } plan_row_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [IDX_W-1:0]      cfg_index = '0;
    logic [DATA_W-1:0]     cfg_data = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata = '0;
    logic                  s_tlast = 1'b0;
    logic [1:0]            s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [7:0]            m_tdata;

    string_pattern_matcher_unit uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #5 aclk = ~aclk;

    // Mirror of the configuration registers
    logic [1:0]            cur_mode = spm_pkg::MODE_EXACT;
    logic [5:0]            cur_len = '0;
    bit                    cur_absent = 1'b0;
    logic [DATA_W-1:0]     cur_words [4] = '{default: '0};

    // Mirror of the stream state, newest byte at index 0
    logic [7:0] recent_bytes [WIN];
    int         byte_count;
    bit         head_agrees;
    bit         pattern_seen;

    logic [1:0] verdicts_due [$];
    logic [1:0] due_verdict;
    plan_row_t  plan [$];

    int errors = 0;
    int n_reqs = 0;
    int n_strings = 0;
    int n_true = 0;
    int n_false = 0;
    int n_abstain = 0;
    int idle_pct = 0;
    int stall_pct = 0;
    int idle_cycles = 0;
    int phase_reqs;

    function automatic logic [7:0] pat_at(int k);
        if (k >= 32)
            return 8'h00;
        return cur_words[k >> 3][(k & 7) * 8 +: 8];
    endfunction

    // Pattern length as the matcher sees it: clamp, then stop at a zero byte
    function automatic int live_len();
        int lim;
        lim = (int'(cur_len) > WIN) ? WIN : int'(cur_len);
        for (int k = 0; k < lim; k++) begin
            if (pat_at(k) == 8'h00)
                return k;
        end
        return lim;
    endfunction

    function automatic bit tail_agrees(int len);
        if (byte_count < len)
            return 1'b0;
        for (int i = 0; i < len; i++) begin
            if (recent_bytes[i] != pat_at(len - 1 - i))
                return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic void clear_stream();
        foreach (recent_bytes[i])
            recent_bytes[i] = 8'h00;
        byte_count   = 0;
        head_agrees  = 1'b1;
        pattern_seen = 1'b0;
    endfunction

    // Advance the mirror by one request; return 1 with the verdict on the last one
    function automatic bit match_step(input ctx_req_t r, output logic [1:0] v);
        int len;
        bit ok;
        len = live_len();
        v   = spm_pkg::VERDICT_FALSE;
        if (!r.is_empty && !r.ctx_missing) begin
            if (byte_count < len && r.ctx_byte != pat_at(byte_count))
                head_agrees = 1'b0;
            for (int i = WIN - 1; i > 0; i--)
                recent_bytes[i] = recent_bytes[i - 1];
            recent_bytes[0] = r.ctx_byte;
            if (byte_count < WIN + 1)
                byte_count++;
            if (tail_agrees(len))
                pattern_seen = 1'b1;
        end
        if (!r.is_last)
            return 1'b0;
        if (cur_absent || r.ctx_missing) begin
            v = spm_pkg::VERDICT_ABSTAIN;
        end else begin
            case (cur_mode)
                spm_pkg::MODE_EXACT:  ok = head_agrees && byte_count == len;
                spm_pkg::MODE_PREFIX: ok = head_agrees && byte_count >= len;
                spm_pkg::MODE_SUFFIX: ok = tail_agrees(len);
                default:              ok = (len == 0) || pattern_seen;
            endcase
            v = ok ? spm_pkg::VERDICT_TRUE : spm_pkg::VERDICT_FALSE;
        end
        clear_stream();
        return 1'b1;
    endfunction

    function automatic void reg_row(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] val);
        plan_row_t row;
        row = '{ROW_REG, idx, val, '0, 1'b0, spm_pkg::VERDICT_FALSE};
        plan.push_back(row);
    endfunction

    function automatic void req_row(logic [7:0] b, bit last, bit empty, bit missing);
        plan_row_t row;
        row = '{ROW_REQ, spm_pkg::REG_MODE, '0, '{b, last, empty, missing}, 1'b0,
                spm_pkg::VERDICT_FALSE};
        plan.push_back(row);
    endfunction

    function automatic void checked_row(logic [7:0] b, bit last, bit empty, bit missing,
                                        logic [1:0] want);
        plan_row_t row;
        row = '{ROW_REQ, spm_pkg::REG_MODE, '0, '{b, last, empty, missing}, 1'b1, want};
        plan.push_back(row);
    endfunction

    // Write one register; cfg_we is dropped by whatever drives next
    task automatic write_reg(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        case (idx)
            spm_pkg::REG_MODE:    cur_mode = val[1:0];
            spm_pkg::REG_LENGTH:  cur_len = val[5:0];
            spm_pkg::REG_MISSING: cur_absent = val[0];
            spm_pkg::REG_PAT0:    cur_words[0] = val;
            spm_pkg::REG_PAT1:    cur_words[1] = val;
            spm_pkg::REG_PAT2:    cur_words[2] = val;
            spm_pkg::REG_PAT3:    cur_words[3] = val;
            default:     ;
        endcase
    endtask

    // Hold the sender until every verdict is out, then let the block go quiet
    task automatic settle(int quiet);
        s_tvalid <= 1'b0;
        cfg_we   <= 1'b0;
        do @(posedge aclk); while (verdicts_due.size() != 0);
        repeat (quiet) @(posedge aclk);
    endtask

    // Offer one request, wait for the handshake, then record the verdict it earns
    task automatic send_req(ctx_req_t r, bit typed, logic [1:0] want);
        logic [1:0] v;
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            cfg_we   <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= r.ctx_byte;
        s_tlast  <= r.is_last;
        s_tuser  <= {r.ctx_missing, r.is_empty};
        cfg_we   <= 1'b0;
        do @(posedge aclk); while (!s_tready);
        n_reqs++;
        phase_reqs++;
        if (match_step(r, v)) begin
            if (typed)
                v = want;
            verdicts_due.push_back(v);
            n_strings++;
            case (v)
                spm_pkg::VERDICT_TRUE:  n_true++;
                spm_pkg::VERDICT_FALSE: n_false++;
                default:                n_abstain++;
            endcase
        end
    endtask

    // Half the time a byte the pattern holds, so partial matches come often
    function automatic logic [7:0] pick_byte();
        if ($urandom_range(1))
            return pat_at($urandom_range(WIN - 1));
        return 8'($urandom_range(255));
    endfunction

    task automatic send_string();
        logic [7:0] body [$];
        ctx_req_t   r;
        int         len;
        int         kind;
        int         n;
        bit         absent_end;
        bit         empty_end;
        len        = live_len();
        kind       = $urandom_range(9);
        absent_end = 1'b0;
        case (kind)
            0, 1, 2: begin
                for (int k = 0; k < len; k++)
                    body.push_back(pat_at(k));
            end
            3, 4: begin
                n = $urandom_range(3);
                repeat (n) body.push_back(pick_byte());
                for (int k = 0; k < len; k++)
                    body.push_back(pat_at(k));
                n = $urandom_range(3);
                repeat (n) body.push_back(pick_byte());
            end
            5: begin
                for (int k = 0; k < len; k++)
                    body.push_back(pat_at(k));
                if (len > 0)
                    body[$urandom_range(len - 1)] = pick_byte();
            end
            6: begin
                n = $urandom_range(6);
                repeat (n) body.push_back(pick_byte());
            end
            7: begin
                // Long string: push the byte count into saturation
                n = $urandom_range(30, 40);
                repeat (n) body.push_back(pick_byte());
                if ($urandom_range(1) && len <= n) begin
                    for (int k = 0; k < len; k++)
                        body[n - len + k] = pat_at(k);
                end
            end
            8: ;
            default: begin
                n = $urandom_range(4);
                repeat (n) body.push_back(pick_byte());
                absent_end = 1'b1;
            end
        endcase
        empty_end = (body.size() == 0) || ($urandom_range(9) == 0);
        foreach (body[i]) begin
            // Sprinkle requests that carry no byte
            if ($urandom_range(99) < 8) begin
                r = '{8'($urandom_range(255)), 1'b0, 1'b1, 1'b0};
                send_req(r, 1'b0, spm_pkg::VERDICT_FALSE);
            end else if ($urandom_range(99) < 4) begin
                r = '{8'($urandom_range(255)), 1'b0, 1'($urandom_range(1)), 1'b1};
                send_req(r, 1'b0, spm_pkg::VERDICT_FALSE);
            end
            r.ctx_byte    = body[i];
            r.is_last     = (i == body.size() - 1) && !empty_end;
            r.is_empty    = 1'b0;
            r.ctx_missing = r.is_last && absent_end;
            send_req(r, 1'b0, spm_pkg::VERDICT_FALSE);
        end
        if (empty_end) begin
            r = '{8'($urandom_range(255)), 1'b1, 1'b1, absent_end};
            send_req(r, 1'b0, spm_pkg::VERDICT_FALSE);
        end
    endtask

    // Pick one setting per phase; the first few pin the extremes
    task automatic configure_phase(int ph);
        logic [DATA_W-1:0]     words [4];
        logic [7:0]            b;
        bit                    wide;
        int                    len;
        wide = (ph % 3 == 0);
        for (int k = 0; k < 32; k++) begin
            if (ph == 0)
                b = 8'hFF;
            else if ($urandom_range(99) < 3)
                b = 8'h00;
            else if (wide)
                b = 8'($urandom_range(1, 255));
            else
                b = 8'h61 + 8'($urandom_range(2));
            words[k >> 3][(k & 7) * 8 +: 8] = b;
        end
        case (ph)
            0:       len = 32;
            1:       len = 0;
            2:       len = 63;
            3:       len = 1;
            default: len = ($urandom_range(9) < 7) ? $urandom_range(1, 6) : $urandom_range(32);
        endcase
        write_reg(spm_pkg::REG_MODE,
                  (ph < 4) ? DATA_W'(ph) : DATA_W'($urandom_range(3)));
        write_reg(spm_pkg::REG_LENGTH, DATA_W'(len));
        write_reg(spm_pkg::REG_MISSING, DATA_W'((ph == 5) || ($urandom_range(9) == 0)));
        write_reg(spm_pkg::REG_PAT0, words[0]);
        write_reg(spm_pkg::REG_PAT1, words[1]);
        write_reg(spm_pkg::REG_PAT2, words[2]);
        write_reg(spm_pkg::REG_PAT3, words[3]);
    endtask

    // Receiver side: stall at random in the phases that ask for it
    always @(posedge aclk)
        m_tready <= ($urandom_range(99) >= stall_pct);

    // Check each verdict against the oldest one due
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (verdicts_due.size() == 0) begin
                errors++;
                $display("%0t: verdict with none due, expected none, got %0d",
                         $time, m_tdata[1:0]);
            end else begin
                due_verdict = verdicts_due.pop_front();
                if (m_tdata[1:0] !== due_verdict) begin
                    errors++;
                    $display("%0t: verdict mismatch, expected %0d, got %0d",
                             $time, due_verdict, m_tdata[1:0]);
                end
            end
        end
    end

    // Watchdog: count cycles in which nothing moves on any port
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        clear_stream();

        // Directed part: registers still at reset to start with (exact, empty pattern)
        checked_row(8'h00, 1, 0, 0, spm_pkg::VERDICT_FALSE);
        checked_row(8'hFF, 1, 1, 0, spm_pkg::VERDICT_TRUE);
        checked_row(8'hFF, 1, 0, 0, spm_pkg::VERDICT_FALSE);
        checked_row(8'h5A, 1, 0, 1, spm_pkg::VERDICT_ABSTAIN);
        reg_row(spm_pkg::REG_MISSING, 64'd1);
        checked_row(8'h61, 1, 0, 0, spm_pkg::VERDICT_ABSTAIN);
        reg_row(spm_pkg::REG_MISSING, 64'd0);
        // Pattern "ab", exact
        reg_row(spm_pkg::REG_PAT0, 64'h6261);
        reg_row(spm_pkg::REG_LENGTH, 64'd2);
        req_row(8'h61, 0, 0, 0);
        req_row(8'h62, 1, 0, 0);
        req_row(8'h61, 0, 0, 0);
        req_row(8'h62, 0, 0, 0);
        req_row(8'h63, 1, 0, 0);
        // Prefix, with an empty request in the middle
        reg_row(spm_pkg::REG_MODE, 64'(spm_pkg::MODE_PREFIX));
        req_row(8'h61, 0, 0, 0);
        req_row(8'h00, 0, 1, 0);
        req_row(8'h62, 0, 0, 0);
        req_row(8'h63, 1, 0, 0);
        // Suffix, with a dropped byte flagged missing
        reg_row(spm_pkg::REG_MODE, 64'(spm_pkg::MODE_SUFFIX));
        req_row(8'h78, 0, 0, 0);
        req_row(8'h61, 0, 0, 1);
        req_row(8'h61, 0, 0, 0);
        req_row(8'h62, 1, 0, 0);
        reg_row(spm_pkg::REG_MODE, 64'(spm_pkg::MODE_CONTAINS));
        req_row(8'h61, 0, 0, 0);
        req_row(8'h62, 0, 0, 0);
        req_row(8'hFF, 1, 0, 0);
        // Length past the window, cut back by the zero after "ab"
        reg_row(spm_pkg::REG_LENGTH, 64'd63);
        reg_row(spm_pkg::REG_PAT1, '1);
        reg_row(spm_pkg::REG_PAT2, '1);
        reg_row(spm_pkg::REG_PAT3, '1);
        req_row(8'hFF, 1, 0, 0);

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (plan[i]) begin
            if (plan[i].kind == ROW_REG) begin
                if (i > 0 && plan[i - 1].kind != ROW_REG)
                    settle(4);
                write_reg(plan[i].idx, plan[i].val);
            end else begin
                send_req(plan[i].req, plan[i].typed, plan[i].want);
            end
        end

        // Random part: one setting and one idling pattern per phase
        for (int ph = 0; ph < PHASES; ph++) begin
            settle(4);
            case (ph % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 65; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 65; end
                default: begin idle_pct = 37; stall_pct = 37; end
            endcase
            configure_phase(ph);
            phase_reqs = 0;
            while (phase_reqs < PHASE_REQS) begin
                send_string();
                if ($urandom_range(99) < 3)
                    settle(0);
            end
        end

        settle(8);
        if (verdicts_due.size() != 0) begin
            errors++;
            $display("%0t: %0d verdicts never arrived", $time, verdicts_due.size());
        end
        $display("Matched %0d requests in %0d strings over %0d settings in four modes.",
                 n_reqs, n_strings, PHASES + 1);
        $display("Verdicts seen: %0d true, %0d false, %0d abstain.",
                 n_true, n_false, n_abstain);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// File: sim.f
src/spm_pkg.sv
src/spm_cell.sv
src/spm_out_buf.sv
src/string_pattern_matcher_unit.sv
src/spm_checker.sv
sim/tb_top.sv
